[design/skmj_pkg.sv]
// ----------------------------------------------------------------------------
// skmj_pkg
// Shared types and constants for the sorted key merge join unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skmj_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Request opcodes
	typedef enum logic [1:0] {
		OP_LEFT_DATA  = 2'd0,
		OP_RIGHT_DATA = 2'd1,
		OP_LEFT_END   = 2'd2,
		OP_RIGHT_END  = 2'd3
	} op_t;

	// Join mode register values
	localparam logic MODE_LEFT  = 1'b0;
	localparam logic MODE_OUTER = 1'b1;

	// Input request
	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [63:0] value;
	} item_t;

	// Output row
	typedef struct packed {
		logic [31:0] out_key;
		logic [63:0] left_value;
		logic        left_present;
		logic [63:0] right_value;
		logic        right_present;
		logic        overflow;
		logic        last_of_run;
	} result_t;

	// Queue entry as held in memory
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] value;
	} entry_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OVF,
		ST_RD,
		ST_CMP
	} state_t;

endpackage

`default_nettype wire

[design/sorted_key_merge_join_unit.sv]
// ----------------------------------------------------------------------------
// sorted_key_merge_join_unit
// Merge join of two ascending key streams held in one queue memory per side.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A request is accepted in the idle
// state; then each merge step passes through a read state (head read from the
// queue memories) and a compare state (compare and pop), and the run closes
// in the read state, which releases the held row, if any, with last_of_run set.
// The number of merge steps that a request triggers is usually 0 or 1 for a
// data request, and as many as it takes to drain the queued entries for an
// end marker. A stalled output makes the sequencer wait. The read and compare
// states are separate because the queue memories have a registered read.
// A full queue gives a single overflow row with zero row fields. Rows leave
// through an output register, so a new request is taken while a finished row
// waits. join_mode is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_merge_join_unit import skmj_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	// configuration
	input  wire logic    cfg_valid,
	output logic         cfg_ready,
	input  wire logic    cfg_data,
	// input requests
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	// output rows
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	// Registers
	state_t             state_q, state_d;
	logic [PTR_W-1:0]   l_head_q, l_head_d, r_head_q, r_head_d;
	logic [CNT_W-1:0]   l_cnt_q, l_cnt_d, r_cnt_q, r_cnt_d;
	logic [1:0]         ended_q, ended_d;
	logic               mode_q;
	logic               pend_valid_q, pend_valid_d;
	result_t            pend_q, pend_d;
	logic               res_valid_q, res_valid_d;
	result_t            res_q, res_d;

	// Queue memories and their read registers
	entry_t             l_mem [QUEUE_DEPTH];
	entry_t             r_mem [QUEUE_DEPTH];
	entry_t             l_rd_q, r_rd_q;

	logic               push_l, push_r;
	logic [PTR_W:0]     l_sum, r_sum;
	logic [PTR_W-1:0]   l_tail, r_tail;
	logic [PTR_W-1:0]   l_head_inc, r_head_inc;
	logic               have_l, have_r, step_go, out_free;
	logic               l_full, r_full;
	logic               emit, pop_l, pop_r;
	result_t            row;

	// Ports
	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Queue pointers
	assign l_sum = {1'b0, l_head_q} + (PTR_W+1)'(l_cnt_q);
	assign r_sum = {1'b0, r_head_q} + (PTR_W+1)'(r_cnt_q);
	assign l_tail = (l_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
		PTR_W'(l_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(l_sum);
	assign r_tail = (r_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
		PTR_W'(r_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(r_sum);
	assign l_head_inc = (l_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : l_head_q + PTR_W'(1);
	assign r_head_inc = (r_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head_q + PTR_W'(1);
	assign l_full = (l_cnt_q == CNT_W'(QUEUE_DEPTH));
	assign r_full = (r_cnt_q == CNT_W'(QUEUE_DEPTH));

	// Merge step possible
	assign have_l  = (l_cnt_q != '0);
	assign have_r  = (r_cnt_q != '0);
	assign step_go = (have_l && have_r) || (have_l && ended_q[1]) || (have_r && ended_q[0]);

	assign out_free = !res_valid_q || result_ready;

	// Compare heads and build the row
	always_comb begin
		row   = '0;
		emit  = 1'b0;
		pop_l = 1'b0;
		pop_r = 1'b0;
		if (have_l && have_r && (l_rd_q.key == r_rd_q.key)) begin
			row.out_key       = l_rd_q.key;
			row.left_value    = l_rd_q.value;
			row.left_present  = 1'b1;
			row.right_value   = r_rd_q.value;
			row.right_present = 1'b1;
			emit  = 1'b1;
			pop_l = 1'b1;
			pop_r = 1'b1;
		end else if (have_l && (!have_r || (l_rd_q.key < r_rd_q.key))) begin
			row.out_key      = l_rd_q.key;
			row.left_value   = l_rd_q.value;
			row.left_present = 1'b1;
			emit  = 1'b1;
			pop_l = 1'b1;
		end else begin
			// right-only row, dropped in left mode
			row.out_key       = r_rd_q.key;
			row.right_value   = r_rd_q.value;
			row.right_present = 1'b1;
			emit  = (mode_q == MODE_OUTER);
			pop_r = 1'b1;
		end
	end

	// Sequencer: next state and outputs
	always_comb begin
		state_d      = state_q;
		l_head_d     = l_head_q;
		r_head_d     = r_head_q;
		l_cnt_d      = l_cnt_q;
		r_cnt_d      = r_cnt_q;
		ended_d      = ended_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		res_valid_d  = res_valid_q && !result_ready;
		res_d        = res_q;
		push_l       = 1'b0;
		push_r       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.op)
						OP_LEFT_DATA: begin
							if (!ended_q[0]) begin
								if (l_full) begin
									state_d = ST_OVF;
								end else begin
									push_l  = 1'b1;
									l_cnt_d = l_cnt_q + CNT_W'(1);
									state_d = ST_RD;
								end
							end
						end
						OP_RIGHT_DATA: begin
							if (!ended_q[1]) begin
								if (r_full) begin
									state_d = ST_OVF;
								end else begin
									push_r  = 1'b1;
									r_cnt_d = r_cnt_q + CNT_W'(1);
									state_d = ST_RD;
								end
							end
						end
						OP_LEFT_END: begin
							ended_d[0] = 1'b1;
							state_d    = ST_RD;
						end
						OP_RIGHT_END: begin
							ended_d[1] = 1'b1;
							state_d    = ST_RD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_OVF: begin
				if (out_free) begin
					res_valid_d       = 1'b1;
					res_d             = '0;
					res_d.overflow    = 1'b1;
					res_d.last_of_run = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_RD: begin
				if (step_go) begin
					state_d = ST_CMP;
				end else if (!pend_valid_q || out_free) begin
					// close the run: release the held row as the last one
					if (pend_valid_q) begin
						res_valid_d       = 1'b1;
						res_d             = pend_q;
						res_d.last_of_run = 1'b1;
						pend_valid_d      = 1'b0;
					end
					if (ended_q == 2'b11) begin
						ended_d = 2'b00;
					end
					state_d = ST_IDLE;
				end
			end
			ST_CMP: begin
				// a new row pushes the held one out; wait if the output is busy
				if (!(emit && pend_valid_q && !out_free)) begin
					if (emit) begin
						if (pend_valid_q) begin
							res_valid_d = 1'b1;
							res_d       = pend_q;
						end
						pend_valid_d = 1'b1;
						pend_d       = row;
					end
					if (pop_l) begin
						l_head_d = l_head_inc;
						l_cnt_d  = l_cnt_q - CNT_W'(1);
					end
					if (pop_r) begin
						r_head_d = r_head_inc;
						r_cnt_d  = r_cnt_q - CNT_W'(1);
					end
					state_d = ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			l_head_q     <= '0;
			r_head_q     <= '0;
			l_cnt_q      <= '0;
			r_cnt_q      <= '0;
			ended_q      <= '0;
			mode_q       <= MODE_LEFT;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			l_head_q     <= l_head_d;
			r_head_q     <= r_head_d;
			l_cnt_q      <= l_cnt_d;
			r_cnt_q      <= r_cnt_d;
			ended_q      <= ended_d;
			pend_valid_q <= pend_valid_d;
			res_valid_q  <= res_valid_d;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
		end
	end

	// Row payload registers
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		res_q  <= res_d;
	end

	// Left queue memory
	always_ff @(posedge clk) begin
		if (push_l) begin
			l_mem[l_tail] <= {item.key, item.value};
		end
		l_rd_q <= l_mem[l_head_q];
	end

	// Right queue memory
	always_ff @(posedge clk) begin
		if (push_r) begin
			r_mem[r_tail] <= {item.key, item.value};
		end
		r_rd_q <= r_mem[r_head_q];
	end

endmodule

`default_nettype wire

[design/skmj_checker.sv]
// ----------------------------------------------------------------------------
// skmj_checker
// Port-level checks on the rows leaving the merge join unit.
// ----------------------------------------------------------------------------
`default_nettype none

module skmj_checker import skmj_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    result_valid,
	input  wire logic    result_ready,
	input  wire result_t result
);

	// A stalled row holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("row changed while stalled");

	// Overflow rows are empty and close their run
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |->
			result.last_of_run && !result.left_present && !result.right_present &&
			result.out_key == '0)
		else $error("malformed overflow row");

	// Absent sides carry zero payload
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(result.left_present || result.left_value == '0) &&
			(result.right_present || result.right_value == '0))
		else $error("payload on an absent side");

	// A joined row holds at least one side
	a_side: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.overflow |-> result.left_present || result.right_present)
		else $error("row with neither side present");

endmodule

bind sorted_key_merge_join_unit skmj_checker u_skmj_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Merge join unit testbench
// Drives left and right key streams into the unit under both join modes and
// checks every output row, field by field, against a row predictor kept in
// the bench. The bench covers directed corner cases, full queues, long output
// stalls and random stream pairs with malformed sequences mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import skmj_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 80;   // covers the longest drain, both queues full
	localparam int HOLD_CYCLES   = 150;

	logic    clk;
	logic    arst_n;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    cfg_data;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// Predictor state
	logic    mode_shadow;
	entry_t  left_fifo[$];
	entry_t  right_fifo[$];
	bit      left_done;
	bit      right_done;
	result_t held_row;
	bit      held_valid;
	result_t pending_rows[$];

	// Run control and statistics
	bit      quiet;
	bit      hold_req;
	int      hold_cnt;
	int      err_cnt;
	int      cycle_cnt;
	int      n_sent;
	int      n_rows;
	int      n_paired;
	int      n_overflow;
	int      n_ignored;
	bit      seen_left_mode;
	bit      seen_outer_mode;

	sorted_key_merge_join_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Row builder; absent sides carry zero payload
	function automatic result_t make_row(input logic [31:0] k, input bit lp,
			input logic [63:0] lv, input bit rp, input logic [63:0] rv);
		result_t r;
		r = '0;
		r.out_key       = k;
		r.left_present  = lp;
		r.left_value    = lp ? lv : 64'd0;
		r.right_present = rp;
		r.right_value   = rp ? rv : 64'd0;
		return r;
	endfunction

	// Hold back one row so the last of a run can be marked
	function automatic void queue_row(input result_t r);
		if (held_valid)
			pending_rows.push_back(held_row);
		held_row   = r;
		held_valid = 1'b1;
		if (r.left_present && r.right_present)
			n_paired++;
	endfunction

	// Expected rows for one accepted request
	function automatic void predict_join(input item_t req);
		entry_t  lh;
		entry_t  rh;
		entry_t  ent;
		result_t ovf;
		bit      hl;
		bit      hr;
		bit      go;
		ent.key   = req.key;
		ent.value = req.value;
		ovf       = '0;
		ovf.overflow    = 1'b1;
		ovf.last_of_run = 1'b1;
		case (req.op)
			OP_LEFT_DATA: begin
				if (left_done) begin
					n_ignored++;
					return;
				end
				if (left_fifo.size() >= QUEUE_DEPTH) begin
					pending_rows.push_back(ovf);
					n_overflow++;
					return;
				end
				left_fifo.push_back(ent);
			end
			OP_RIGHT_DATA: begin
				if (right_done) begin
					n_ignored++;
					return;
				end
				if (right_fifo.size() >= QUEUE_DEPTH) begin
					pending_rows.push_back(ovf);
					n_overflow++;
					return;
				end
				right_fifo.push_back(ent);
			end
			OP_LEFT_END:  left_done = 1'b1;
			OP_RIGHT_END: right_done = 1'b1;
			default: ;
		endcase

		// Merge for as long as the heads allow
		go = 1'b1;
		while (go) begin
			hl = left_fifo.size() != 0;
			hr = right_fifo.size() != 0;
			if (hl)
				lh = left_fifo[0];
			if (hr)
				rh = right_fifo[0];
			if (hl && hr) begin
				if (lh.key == rh.key) begin
					queue_row(make_row(lh.key, 1'b1, lh.value, 1'b1, rh.value));
					lh = left_fifo.pop_front();
					rh = right_fifo.pop_front();
				end else if (lh.key < rh.key) begin
					queue_row(make_row(lh.key, 1'b1, lh.value, 1'b0, 64'd0));
					lh = left_fifo.pop_front();
				end else begin
					if (mode_shadow == MODE_OUTER)
						queue_row(make_row(rh.key, 1'b0, 64'd0, 1'b1, rh.value));
					rh = right_fifo.pop_front();
				end
			end else if (hl && right_done) begin
				queue_row(make_row(lh.key, 1'b1, lh.value, 1'b0, 64'd0));
				lh = left_fifo.pop_front();
			end else if (hr && left_done) begin
				if (mode_shadow == MODE_OUTER)
					queue_row(make_row(rh.key, 1'b0, 64'd0, 1'b1, rh.value));
				rh = right_fifo.pop_front();
			end else begin
				go = 1'b0;
			end
		end

		// Both streams finished: ready for a new pair
		if (left_done && right_done && left_fifo.size() == 0 && right_fifo.size() == 0) begin
			left_done  = 1'b0;
			right_done = 1'b0;
		end
		if (held_valid) begin
			held_row.last_of_run = 1'b1;
			pending_rows.push_back(held_row);
			held_valid = 1'b0;
		end
	endfunction

	// Offer one request, with an occasional gap in front of it
	task automatic offer(input op_t op, input logic [31:0] k, input logic [63:0] v);
		item_t req;
		int    gap;
		req.op    = op;
		req.key   = k;
		req.value = v;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (!item_ready);
		predict_join(req);
		n_sent++;
	endtask

	// Sender pause: all rows in, then let the unit settle
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// join_mode write, only while the unit is idle
	task automatic write_mode(input logic m);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		mode_shadow = m;
		if (m == MODE_OUTER)
			seen_outer_mode = 1'b1;
		else
			seen_left_mode = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Corner cases in both modes
	task automatic test_directed();
		write_mode(MODE_LEFT);
		offer(OP_LEFT_DATA, 32'd0, 64'd0);
		offer(OP_RIGHT_DATA, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);         // pair at key zero
		offer(OP_RIGHT_DATA, 32'd5, 64'h0123_4567_89AB_CDEF);
		offer(OP_LEFT_DATA, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);  // lone right dropped
		offer(OP_LEFT_END, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		offer(OP_LEFT_DATA, 32'd7, 64'd7);                            // after end: ignored
		offer(OP_LEFT_END, 32'd0, 64'd0);                             // repeated end
		offer(OP_RIGHT_END, 32'd0, 64'd0);                            // drains left
		write_mode(MODE_OUTER);
		offer(OP_RIGHT_DATA, 32'd10, 64'hA5A5_A5A5_5A5A_5A5A);
		offer(OP_LEFT_DATA, 32'd20, 64'h5A5A_5A5A_A5A5_A5A5);         // lone right kept
		offer(OP_RIGHT_DATA, 32'd20, 64'hDEAD_BEEF_0000_0001);
		offer(OP_LEFT_DATA, 32'd30, 64'h8000_0000_0000_0000);
		offer(OP_RIGHT_END, 32'd0, 64'd0);
		offer(OP_RIGHT_DATA, 32'd40, 64'd1);                          // after end: ignored
		offer(OP_RIGHT_END, 32'd0, 64'd0);
		offer(OP_LEFT_END, 32'd0, 64'd0);                             // both ended: reset
		// keys out of order, compared as they stand
		offer(OP_LEFT_DATA, 32'd50, 64'd50);
		offer(OP_LEFT_DATA, 32'd3, 64'd3);
		offer(OP_RIGHT_DATA, 32'd3, 64'd33);
		offer(OP_RIGHT_END, 32'd0, 64'd0);
		offer(OP_LEFT_END, 32'd0, 64'd0);
		wait_drained();
	endtask

	// Fill each queue past its depth, then drain it with the other side's end
	task automatic test_queue_full();
		logic [31:0] k;
		write_mode(MODE_OUTER);
		k = $urandom_range(0, 32'hFFFF_0000);
		repeat (QUEUE_DEPTH + 2) begin
			k = k + $urandom_range(0, 2);
			offer(OP_LEFT_DATA, k, {$urandom, $urandom});
		end
		offer(OP_RIGHT_END, $urandom, {$urandom, $urandom});
		offer(OP_LEFT_END, $urandom, {$urandom, $urandom});
		repeat (QUEUE_DEPTH + 2) begin
			k = k + $urandom_range(0, 2);
			offer(OP_RIGHT_DATA, k, {$urandom, $urandom});
		end
		offer(OP_LEFT_END, $urandom, {$urandom, $urandom});
		offer(OP_RIGHT_END, $urandom, {$urandom, $urandom});
		wait_drained();
	endtask

	// Long output stall while requests keep coming, so the unit backs up
	task automatic test_output_stall();
		logic [31:0] k;
		write_mode(MODE_OUTER);
		hold_req = 1'b1;
		k = $urandom;
		repeat (12) begin
			k = k + 1;
			offer(OP_LEFT_DATA, k, {$urandom, $urandom});
			offer(OP_RIGHT_DATA, k, {$urandom, $urandom});
		end
		offer(OP_LEFT_END, $urandom, {$urandom, $urandom});
		offer(OP_RIGHT_END, $urandom, {$urandom, $urandom});
		wait_drained();
	endtask

	// Random stream pairs, mostly well formed, some broken
	task automatic test_random_streams(input int n_items);
		logic [31:0] lkeys[$];
		logic [31:0] rkeys[$];
		logic [31:0] cursor;
		logic [31:0] tmp;
		op_t         first_end;
		op_t         other_end;
		op_t         late_op;
		int          start;
		int          len;
		int          pick;
		int          li;
		int          ri;
		start = n_sent;
		quiet = 1'b1;
		while (n_sent - start < n_items) begin
			if (n_sent - start > 40)
				quiet = 1'b0;
			if ($urandom_range(0, 2) == 0)
				write_mode(1'($urandom_range(0, 1)));

			// Build both sides over a shared ascending key range
			lkeys.delete();
			rkeys.delete();
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0:       cursor = 32'd0;
				1:       cursor = 32'hFFFF_FFFF - 3 * len;
				default: cursor = $urandom_range(0, 32'hFFFF_0000);
			endcase
			for (int i = 0; i < len; i++) begin
				cursor = cursor + $urandom_range(1, 3);
				pick   = $urandom_range(0, 3);
				if (pick != 1)
					lkeys.push_back(cursor);
				if (pick != 0)
					rkeys.push_back(cursor);
			end
			if ($urandom_range(0, 5) == 0 && lkeys.size() > 1) begin
				tmp      = lkeys[0];
				lkeys[0] = lkeys[1];
				lkeys[1] = tmp;
			end

			// Interleave the two sides at random
			li = 0;
			ri = 0;
			while (li < lkeys.size() || ri < rkeys.size()) begin
				if (ri >= rkeys.size() || (li < lkeys.size() && $urandom_range(0, 1))) begin
					offer(OP_LEFT_DATA, lkeys[li], {$urandom, $urandom});
					li++;
				end else begin
					offer(OP_RIGHT_DATA, rkeys[ri], {$urandom, $urandom});
					ri++;
				end
			end

			// End markers in random order, sometimes with late data or a repeat
			first_end = $urandom_range(0, 1) ? OP_LEFT_END : OP_RIGHT_END;
			other_end = (first_end == OP_LEFT_END) ? OP_RIGHT_END : OP_LEFT_END;
			late_op   = (first_end == OP_LEFT_END) ? OP_LEFT_DATA : OP_RIGHT_DATA;
			offer(first_end, $urandom, {$urandom, $urandom});
			if ($urandom_range(0, 4) == 0) begin
				offer(late_op, $urandom, {$urandom, $urandom});
				offer(first_end, $urandom, {$urandom, $urandom});
			end
			offer(other_end, $urandom, {$urandom, $urandom});
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end
		quiet = 1'b0;
		wait_drained();
	endtask

	// Receiver: random back-pressure, plus a long hold when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= quiet || ($urandom_range(0, 99) >= 9);
		end
	end

	// Row checker against the oldest expected row
	always @(posedge clk) begin : row_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			n_rows++;
			if (pending_rows.size() == 0) begin
				$error("unexpected row: out_key %h", result.out_key);
				err_cnt++;
			end else begin
				want = pending_rows.pop_front();
				if (result.out_key !== want.out_key) begin
					$error("out_key: expected %h, got %h", want.out_key, result.out_key);
					err_cnt++;
				end
				if (result.left_value !== want.left_value) begin
					$error("left_value: expected %h, got %h", want.left_value,
						result.left_value);
					err_cnt++;
				end
				if (result.left_present !== want.left_present) begin
					$error("left_present: expected %b, got %b", want.left_present,
						result.left_present);
					err_cnt++;
				end
				if (result.right_value !== want.right_value) begin
					$error("right_value: expected %h, got %h", want.right_value,
						result.right_value);
					err_cnt++;
				end
				if (result.right_present !== want.right_present) begin
					$error("right_present: expected %b, got %b", want.right_present,
						result.right_present);
					err_cnt++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %b, got %b", want.overflow, result.overflow);
					err_cnt++;
				end
				if (result.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run,
						result.last_of_run);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Test sequence
	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		mode_shadow  = MODE_LEFT;
		left_done    = 1'b0;
		right_done   = 1'b0;
		held_valid   = 1'b0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		hold_cnt     = 0;
		err_cnt      = 0;
		cycle_cnt    = 0;
		n_sent       = 0;
		n_rows       = 0;
		n_paired     = 0;
		n_overflow   = 0;
		n_ignored    = 0;
		seen_left_mode  = 1'b0;
		seen_outer_mode = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_queue_full();
		test_output_stall();
		test_random_streams(40);
		write_mode(MODE_LEFT);

		$display("Run covered %0d requests and %0d rows: %0d paired, %0d overflow, %0d ignored.",
			n_sent, n_rows, n_paired, n_overflow, n_ignored);
		$display("Left join mode used: %0d, outer join mode used: %0d.",
			seen_left_mode, seen_outer_mode);
		if (err_cnt == 0 && pending_rows.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
